/* sv/usbsr_pkg.sv */
// types, codes and constants shared by the usb suspend/resume controller
`default_nettype none

package usbsr_pkg;

  // resume state machine phases
  typedef enum logic [1:0] {
    PH_OFF   = 2'd0,
    PH_WAIT  = 2'd1,
    PH_START = 2'd2,
    PH_ON    = 2'd3
  } phase_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_IRQ_EN    = 2'd0,
    CFG_SUSP_EN   = 2'd1,
    CFG_FRAME_INT = 2'd2
  } cfg_idx_e;

  // interrupt enable bit positions
  localparam int unsigned EN_SOF  = 0;
  localparam int unsigned EN_RST  = 2;
  localparam int unsigned EN_WKUP = 5;
  localparam int unsigned EN_SUSP = 6;
  localparam int unsigned EN_ESOF = 7;

  localparam logic [7:0] LATER_TICKS  = 8'd2;
  localparam logic [7:0] RESUME_TICKS = 8'd10;
  localparam logic [2:0] MISSED_LIMIT = 3'd3;
  localparam logic [2:0] MISSED_MAX   = 3'd7;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_W       = 9;
  localparam int unsigned OUT_W      = 9;
  localparam int unsigned TDATA_W    = 16;

  typedef struct packed {
    phase_e      phase;
    logic [7:0]  ticks;
    logic        rw_on;
    logic [2:0]  missed;
    logic [15:0] frame_cnt;
    logic        resume;
    logic        suspend;
    logic        lowpower;
  } state_t;

  typedef struct packed {
    logic [7:0]  irq_en;
    logic        susp_en;
    logic [15:0] frame_int;
  } cfg_t;

  typedef struct packed {
    logic rw_req;
    logic dp_high;
    logic esof;
    logic susp;
    logic wkup;
    logic err;
    logic ovr;
    logic rst;
    logic sof;
  } item_t;

  typedef struct packed {
    logic       rw_active;
    phase_e     phase;
    logic       frame_tick;
    logic       bus_reset;
    logic       reset_pulse;
    logic       low_power;
    logic       suspend_mode;
    logic       resume_drive;
  } result_t;

endpackage

`default_nettype wire

/* sv/usbsr_step.sv */
// next-state and result logic for one interrupt-status snapshot
`default_nettype none

module usbsr_step (
  input  wire usbsr_pkg::state_t  state_i,
  input  wire usbsr_pkg::cfg_t    cfg_i,
  input  wire usbsr_pkg::item_t   item_i,
  output usbsr_pkg::state_t  state_o,
  output usbsr_pkg::result_t result_o
);
  import usbsr_pkg::*;

  always_comb begin
    state_t s;
    logic   sof, rst, wkup, susp, esof;
    logic   pulse, tick;

    s     = state_i;
    sof   = item_i.sof  & cfg_i.irq_en[EN_SOF];
    rst   = item_i.rst  & cfg_i.irq_en[EN_RST];
    wkup  = item_i.wkup & cfg_i.irq_en[EN_WKUP];
    susp  = item_i.susp & cfg_i.irq_en[EN_SUSP];
    esof  = item_i.esof & cfg_i.irq_en[EN_ESOF];
    pulse = 1'b0;
    tick  = 1'b0;

    // remote wakeup goes first
    if (item_i.rw_req) begin
      s.resume   = 1'b0;
      s.suspend  = 1'b0;
      s.lowpower = 1'b0;
      s.phase    = PH_START;
      s.rw_on    = 1'b1;
    end

    // frame divider
    if (sof) begin
      if (s.frame_cnt == cfg_i.frame_int) begin
        s.frame_cnt = '0;
        tick        = 1'b1;
      end else begin
        s.frame_cnt = s.frame_cnt + 16'd1;
      end
    end

    if (wkup) begin
      if (!s.rw_on) begin
        s.resume   = 1'b0;
        s.suspend  = 1'b0;
        s.lowpower = 1'b0;
        s.phase    = PH_OFF;
      end else begin
        s.phase = PH_ON;
      end
    end

    if (susp) begin
      if (cfg_i.susp_en) begin
        pulse      = 1'b1;
        s.suspend  = 1'b1;
        s.lowpower = 1'b1;
      end else begin
        s.ticks = LATER_TICKS;
        s.phase = PH_WAIT;
      end
    end

    if (esof) begin
      if (item_i.dp_high) begin
        if (s.missed != MISSED_MAX) s.missed = s.missed + 3'd1;
        if (s.missed > MISSED_LIMIT && !s.suspend) begin
          pulse    = 1'b1;
          s.missed = '0;
        end
      end else begin
        s.missed = '0;
      end

      // resume timing tick
      unique case (s.phase)
        PH_WAIT: begin
          s.ticks = s.ticks - 8'd1;
          if (s.ticks == 8'd0) s.phase = PH_START;
        end
        PH_START: begin
          s.resume = 1'b1;
          s.phase  = PH_ON;
          s.ticks  = RESUME_TICKS;
        end
        PH_ON: begin
          s.ticks = s.ticks - 8'd1;
          if (s.ticks == 8'd0) begin
            s.resume = 1'b0;
            s.phase  = PH_OFF;
            s.rw_on  = 1'b0;
          end
        end
        default: s.phase = PH_OFF;
      endcase
    end

    state_o               = s;
    result_o.resume_drive = s.resume;
    result_o.suspend_mode = s.suspend;
    result_o.low_power    = s.lowpower;
    result_o.reset_pulse  = pulse;
    result_o.bus_reset    = rst;
    result_o.frame_tick   = tick;
    result_o.phase        = s.phase;
    result_o.rw_active    = s.rw_on;
  end

endmodule

`default_nettype wire

/* sv/usb_suspend_resume_controller.sv */
// top level of the usb full-speed device suspend/resume controller
`default_nettype none

// Takes one interrupt-status snapshot per request and returns exactly one
// result per request. A request is held in an input register; once the output
// register is free, the suspend/resume state is updated by one pass of logic
// and the result is captured in the output register. One request is accepted
// every clock cycle while the consumer keeps up. While a result waits for the
// consumer the input register can still take one request; after that the input
// stalls until the waiting result is taken. The sustained rate is set by the
// single state update per cycle. Configuration writes take effect at the next
// edge and should only be done while no request is in flight.
module usb_suspend_resume_controller (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  // configuration write port
  input  wire                              cfg_we_i,
  input  wire [1:0]                        cfg_index_i,
  input  wire [usbsr_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // request stream
  input  wire                              s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // tdata from bit 0: sof_flag, reset_flag, overrun_flag, error_flag,
  // wakeup_flag, suspend_flag, esof_flag, line_dp_high,
  // remote_wakeup_request, zero fill
  input  wire [usbsr_pkg::TDATA_W-1:0]     s_axis_tdata_i,
  // result stream
  output logic                             m_axis_tvalid_o,
  input  wire                              m_axis_tready_i,
  // tdata from bit 0: resume_drive, suspend_mode, low_power,
  // force_reset_pulse, bus_reset_seen, frame_tick, resume_phase (2 bits),
  // remote_wakeup_active, zero fill
  output logic [usbsr_pkg::TDATA_W-1:0]    m_axis_tdata_o
);
  import usbsr_pkg::*;

  // configuration registers
  cfg_t    cfg_q;

  // input register
  logic    in_valid_q;
  item_t   in_item_q;

  // suspend/resume state
  state_t  state_q, state_d;
  result_t result_d;

  // output register
  logic    out_valid_q;
  result_t out_res_q;

  logic    advance;
  logic    s_accept;

  // move the held request into the output register when it is free
  assign advance         = in_valid_q & (~out_valid_q | m_axis_tready_i);
  assign s_axis_tready_o = ~in_valid_q | advance;
  assign s_accept        = s_axis_tvalid_i & s_axis_tready_o;

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.irq_en    <= '0;
      cfg_q.susp_en   <= 1'b1;
      cfg_q.frame_int <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_IRQ_EN:    cfg_q.irq_en    <= cfg_data_i[7:0];
        CFG_SUSP_EN:   cfg_q.susp_en   <= cfg_data_i[0];
        CFG_FRAME_INT: cfg_q.frame_int <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  // input payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_item_q <= s_axis_tdata_i[IN_W-1:0];
    end
  end

  usbsr_step u_step (
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .item_i   (in_item_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // state commits only when the request moves to the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_OFF, default: '0};
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= result_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(TDATA_W-OUT_W){1'b0}}, out_res_q};

`ifndef ASSERT_OFF
  // a result always follows a request leaving the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result register not loaded after advance");

  // a frame tick restarts the frame divider
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && result_d.frame_tick |=> state_q.frame_cnt == 16'd0)
    else $error("frame divider not cleared on frame tick");

  // the late-resume wait never sits at a zero tick count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PH_WAIT |-> state_q.ticks != 8'd0)
    else $error("resume wait phase with zero ticks");

  // the input side only stalls while it holds a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> in_valid_q && out_valid_q && !m_axis_tready_i)
    else $error("input stalled without a blocked request");
`endif

endmodule

`default_nettype wire

/* tb/usbsr_checker.sv */
// checker for the usb suspend/resume controller: predicts each result and compares it
`timescale 1ns / 100ps

module usbsr_checker
  import usbsr_pkg::*;
(
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire [1:0]            cfg_index_i,
  input  wire [CFG_DATA_W-1:0] cfg_data_i,
  input  wire                  req_valid_i,
  input  wire                  req_ready_i,
  input  wire [TDATA_W-1:0]    req_data_i,
  input  wire                  res_valid_i,
  input  wire                  res_ready_i,
  input  wire [TDATA_W-1:0]    res_data_i,
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   checked_o,
  output int                   pulses_o,
  output int                   ticks_o,
  output int                   resumes_o
);

  state_t  st;
  cfg_t    cfg;
  result_t status_q[$];
  result_t want;
  result_t got;

  // one snapshot through the controller state, same order as the hardware handles flags
  task automatic advance_status(input item_t it, output result_t r);
    logic sof_hit, rst_hit, wkup_hit, susp_hit, esof_hit;
    sof_hit  = it.sof  & cfg.irq_en[EN_SOF];
    rst_hit  = it.rst  & cfg.irq_en[EN_RST];
    wkup_hit = it.wkup & cfg.irq_en[EN_WKUP];
    susp_hit = it.susp & cfg.irq_en[EN_SUSP];
    esof_hit = it.esof & cfg.irq_en[EN_ESOF];
    r = '0;
    if (it.rw_req) begin
      st.resume   = 1'b0;
      st.suspend  = 1'b0;
      st.lowpower = 1'b0;
      st.phase    = PH_START;
      st.rw_on    = 1'b1;
    end
    if (sof_hit) begin
      if (st.frame_cnt == cfg.frame_int) begin
        st.frame_cnt = '0;
        r.frame_tick = 1'b1;
      end else begin
        st.frame_cnt = st.frame_cnt + 16'd1;
      end
    end
    r.bus_reset = rst_hit;
    if (wkup_hit) begin
      if (!st.rw_on) begin
        st.resume   = 1'b0;
        st.suspend  = 1'b0;
        st.lowpower = 1'b0;
        st.phase    = PH_OFF;
      end else begin
        st.phase = PH_ON;
      end
    end
    if (susp_hit) begin
      if (cfg.susp_en) begin
        r.reset_pulse = 1'b1;
        st.suspend    = 1'b1;
        st.lowpower   = 1'b1;
      end else begin
        st.ticks = LATER_TICKS;
        st.phase = PH_WAIT;
      end
    end
    if (esof_hit) begin
      if (it.dp_high) begin
        if (st.missed < MISSED_MAX) st.missed = st.missed + 3'd1;
        if (st.missed > MISSED_LIMIT && !st.suspend) begin
          r.reset_pulse = 1'b1;
          st.missed     = '0;
        end
      end else begin
        st.missed = '0;
      end
      case (st.phase)
        PH_WAIT: begin
          st.ticks = st.ticks - 8'd1;
          if (st.ticks == 8'd0) st.phase = PH_START;
        end
        PH_START: begin
          st.resume = 1'b1;
          st.phase  = PH_ON;
          st.ticks  = RESUME_TICKS;
        end
        PH_ON: begin
          st.ticks = st.ticks - 8'd1;
          if (st.ticks == 8'd0) begin
            st.resume = 1'b0;
            st.phase  = PH_OFF;
            st.rw_on  = 1'b0;
          end
        end
        default: st.phase = PH_OFF;
      endcase
    end
    r.resume_drive = st.resume;
    r.suspend_mode = st.suspend;
    r.low_power    = st.lowpower;
    r.phase        = st.phase;
    r.rw_active    = st.rw_on;
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st.phase     = PH_OFF;
      st.ticks     = '0;
      st.rw_on     = 1'b0;
      st.missed    = '0;
      st.frame_cnt = '0;
      st.resume    = 1'b0;
      st.suspend   = 1'b0;
      st.lowpower  = 1'b0;
      cfg.irq_en    = '0;
      cfg.susp_en   = 1'b1;
      cfg.frame_int = '0;
      status_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
      pulses_o     = 0;
      ticks_o      = 0;
      resumes_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_IRQ_EN:    cfg.irq_en    = cfg_data_i[7:0];
          CFG_SUSP_EN:   cfg.susp_en   = cfg_data_i[0];
          CFG_FRAME_INT: cfg.frame_int = cfg_data_i[15:0];
          default: ;
        endcase
      end
      // results first, so a result can never match the request taken on the same edge
      if (res_valid_i && res_ready_i) begin
        got = result_t'(res_data_i[OUT_W-1:0]);
        if (status_q.size() == 0) begin
          $display("%0t: no result expected, got 0x%03h", $time, got);
          fail_count_o++;
        end else begin
          want = status_q.pop_front();
          check_field("resume_drive", want.resume_drive, got.resume_drive);
          check_field("suspend_mode", want.suspend_mode, got.suspend_mode);
          check_field("low_power", want.low_power, got.low_power);
          check_field("force_reset_pulse", want.reset_pulse, got.reset_pulse);
          check_field("bus_reset_seen", want.bus_reset, got.bus_reset);
          check_field("frame_tick", want.frame_tick, got.frame_tick);
          check_field("resume_phase", want.phase, got.phase);
          check_field("remote_wakeup_active", want.rw_active, got.rw_active);
          checked_o++;
          pulses_o  += want.reset_pulse;
          ticks_o   += want.frame_tick;
          resumes_o += want.resume_drive;
        end
      end
      if (req_valid_i && req_ready_i) begin
        advance_status(item_t'(req_data_i[IN_W-1:0]), want);
        status_q.push_back(want);
      end
      pending_o = status_q.size();
    end
  end

endmodule

/* tb/tb.sv */
// testbench top for the usb suspend/resume controller: stimulus, stalls and verdict
`timescale 1ns / 100ps

module tb;
  import usbsr_pkg::*;

  localparam int STALL_LIMIT = 1000;  // cycles with no accept on either side
  localparam int LONG_HOLD   = 60;    // consumer hold-off that backs up the pipeline

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [1:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  req_valid;
  logic                  req_ready;
  logic [TDATA_W-1:0]    req_data;
  logic                  res_valid;
  logic                  res_ready;
  logic [TDATA_W-1:0]    res_data;

  int fails, pending, checked, pulses, ticks, resumes;
  int sent;
  int stall_cycles = 0;
  bit idle_on;    // random gaps and stalls allowed
  int hold_reqs;  // long consumer hold-offs asked for so far

  always #6 clk_i = ~clk_i;

  usb_suspend_resume_controller u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (req_valid),
    .s_axis_tready_o (req_ready),
    .s_axis_tdata_i  (req_data),
    .m_axis_tvalid_o (res_valid),
    .m_axis_tready_i (res_ready),
    .m_axis_tdata_o  (res_data)
  );

  usbsr_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .req_valid_i  (req_valid),
    .req_ready_i  (req_ready),
    .req_data_i   (req_data),
    .res_valid_i  (res_valid),
    .res_ready_i  (res_ready),
    .res_data_i   (res_data),
    .fail_count_o (fails),
    .pending_o    (pending),
    .checked_o    (checked),
    .pulses_o     (pulses),
    .ticks_o      (ticks),
    .resumes_o    (resumes)
  );

  // mostly quiet flags with a random D+ level; sprinkled bits keep sequences honest
  function automatic item_t sparse_bits();
    item_t v;
    v = '0;
    for (int k = 0; k < IN_W; k++) v[k] = ($urandom_range(0, 15) == 0);
    v.dp_high = 1'($urandom_range(0, 1));
    return v;
  endfunction

  // offer one request after an optional idle gap; entered and left at a falling edge
  task automatic send(input item_t it);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_valid <= 1'b1;
    req_data  <= TDATA_W'(it);
    do @(posedge clk_i); while (!req_ready);
    sent++;
    @(negedge clk_i);
  endtask

  // register writes only once every result is back and the pipeline has drained
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_mode(input logic [7:0] en, input logic susp, input logic [15:0] interval);
    write_reg(CFG_IRQ_EN, 16'(en));
    write_reg(CFG_SUSP_EN, 16'(susp));
    write_reg(CFG_FRAME_INT, interval);
  endtask

  // a run of expected-SOF ticks with no wakeup, suspend or remote wakeup mixed in
  task automatic esof_run(input int len, input bit dp_forced);
    item_t v;
    repeat (len) begin
      v = sparse_bits();
      v.rw_req = 1'b0;
      v.wkup   = 1'b0;
      v.susp   = 1'b0;
      v.esof   = 1'b1;
      if (dp_forced) v.dp_high = 1'b1;
      send(v);
    end
  endtask

  // mix of well-formed resume / suspend / missed-frame sequences, noise and broken ones
  task automatic run_random(input int n);
    int   start;
    item_t v;
    start = sent;
    while (sent - start < n) begin
      case ($urandom_range(0, 9))
        0, 1: send(item_t'($urandom_range(0, 511)));
        2, 3: begin
          // remote wakeup carried through start, drive and release
          v = sparse_bits();
          v.rw_req = 1'b1;
          send(v);
          esof_run($urandom_range(10, 14), 1'b0);
        end
        4, 5: begin
          // suspend request: either forced suspend or delayed resume
          v = sparse_bits();
          v.susp = 1'b1;
          v.rw_req = 1'b0;
          send(v);
          esof_run($urandom_range(2, 16), 1'b0);
        end
        6: begin
          // D+ stuck high across expected-SOFs
          v = sparse_bits();
          v.susp = 1'($urandom_range(0, 1));
          send(v);
          esof_run($urandom_range(3, 8), 1'b1);
        end
        7: begin
          repeat ($urandom_range(2, 10)) begin
            v = sparse_bits();
            v.sof = 1'b1;
            send(v);
          end
        end
        8: begin
          v = sparse_bits();
          v.wkup = 1'b1;
          send(v);
          esof_run($urandom_range(1, 5), 1'b0);
        end
        default: begin
          // remote wakeup followed by a host wakeup, which moves it straight to the on phase
          v = sparse_bits();
          v.rw_req = 1'b1;
          send(v);
          v = sparse_bits();
          v.wkup = 1'b1;
          v.rw_req = 1'b0;
          send(v);
          esof_run($urandom_range(0, 3), 1'b0);
        end
      endcase
    end
  endtask

  // consumer side: random stall bursts, one long hold-off on request
  initial begin
    int len;
    int holds_done;
    holds_done = 0;
    res_ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_reqs != holds_done) begin
        holds_done++;
        res_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        len = $urandom_range(1, 5);
        res_ready <= 1'b0;
        repeat (len - 1) @(negedge clk_i);
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // no-progress watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_valid && req_ready) || (res_valid && res_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    rst_ni    = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_IRQ_EN;
    cfg_data  = '0;
    req_valid = 1'b0;
    req_data  = '0;
    sent      = 0;
    idle_on   = 1'b1;
    hold_reqs = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: every flag enabled, suspend allowed, tick on every sof
    set_mode(8'hFF, 1'b1, 16'd0);
    send(item_t'(9'h000));            // nothing pending
    send(item_t'(9'h020));            // suspend: forced reset, suspend and low power
    repeat (8) send(item_t'(9'h0C0)); // esof with D+ high while suspended, counter saturates
    send(item_t'(9'h010));            // host wakeup with no remote wakeup clears control
    send(item_t'(9'h0C0));            // saturated counter now fires a forced reset
    send(item_t'(9'h001));            // sof, interval zero ticks every time
    send(item_t'(9'h002));            // bus reset
    send(item_t'(9'h00C));            // overrun and error are just acknowledged
    send(item_t'(9'h1FF));            // everything at once, resume counter wraps below zero
    send(item_t'(9'h100));            // remote wakeup request
    send(item_t'(9'h040));            // start -> resume driven for ten ticks
    send(item_t'(9'h010));            // host wakeup during remote wakeup keeps the count
    send(item_t'(9'h040));

    // nothing enabled: only remote wakeup has any effect
    set_mode(8'h00, 1'b0, 16'd0);
    run_random(60);

    // delayed resume path with a divided frame tick; consumer holds off at the start
    set_mode(8'hFF, 1'b0, 16'd3);
    hold_reqs++;
    run_random(250);

    set_mode(8'($urandom_range(0, 255)) | 8'hA0, 1'($urandom_range(0, 1)),
             16'($urandom_range(3, 9)));
    run_random(250);

    // widest interval, then lowered below the running frame count
    set_mode(8'($urandom_range(0, 255)), 1'b1, 16'hFFFF);
    run_random(200);

    set_mode(8'hFF, 1'b0, 16'd1);
    run_random(200);
    idle_on = 1'b0;
    run_random(370);

    req_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("covered %0d requests over six enable/suspend/interval settings", sent);
    $display("checked %0d results: %0d forced resets, %0d frame ticks, %0d with resume driven",
             checked, pulses, ticks, resumes);
    if (fails == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* usb_suspend_resume_controller.f */
sv/usbsr_pkg.sv
sv/usbsr_step.sv
sv/usb_suspend_resume_controller.sv
tb/usbsr_checker.sv
tb/tb.sv
